FILE: rtl/core/worst_fit_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Worst-fit block allocator assertion macros
// Concurrent check helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define WFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WFBA_ASSERT_IMP(lbl, ante, cons, msg)
`define WFBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/wfba_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit block allocator package
// Shared command codes, field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package wfba_pkg;

  localparam int IDX_PORT_W  = 4;
  localparam int SIZE_PORT_W = 16;
  localparam int CNT_W       = 5;
  localparam int SUM_W       = 20;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // broadcast operations from the controller to every cell
  typedef struct packed {
    logic load;
    logic mark;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: rtl/core/worst_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Worst-fit block allocator top level
// Block size table in a chain of cells searched by a travelling token.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): command 0 loads size_value into
//   entry entry_index; command 1 requests a block larger than size_value.
//   Result channel (out_valid / out_stall): one item per input item with the
//   grant flag, index, fragment and the running fragment total.
//   cfg_wr_en / cfg_wr_data set block_count; write it only while idle.
// Flow:
//   A load writes its entry on acceptance; the finish state answers it.
//   A request's search token walks the cell chain one cell per cycle, then
//   the scan state commits the mark and total and the finish state presents
//   the result. One item is in work at a time; the next is taken once the
//   result is registered, even if it still waits at the output.
// Reset: every block size is zero, every block free, total and block_count
//   zero. While out_stall is high the result holds and the block finishes
//   at most the next item, then holds in_stall high.
// ----------------------------------------------------------------------------
`include "worst_fit_block_allocator_top_defines.svh"

module worst_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wfba_pkg::CNT_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [wfba_pkg::IDX_PORT_W-1:0]      in_entry_index,
  input  logic [wfba_pkg::SIZE_PORT_W-1:0]     in_size_value,
  input  logic                                 in_last_request,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_granted,
  output logic [wfba_pkg::IDX_PORT_W-1:0]      out_granted_index,
  output logic [wfba_pkg::SIZE_PORT_W-1:0]     out_fragment,
  output logic [wfba_pkg::SUM_W-1:0]           out_total_fragment
);

  localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int AW    = (IDX_W > wfba_pkg::IDX_PORT_W) ? IDX_W : wfba_pkg::IDX_PORT_W;
  localparam int CW    = (IDX_W + 1 > wfba_pkg::CNT_W) ? IDX_W + 1 : wfba_pkg::CNT_W;
  localparam int ADD_W = ((SIZE_BITS > wfba_pkg::SUM_W) ? SIZE_BITS : wfba_pkg::SUM_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [wfba_pkg::CNT_W-1:0]      blk_cnt_r, blk_cnt_nxt;
  logic [wfba_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic                            last_r, last_nxt;
  logic                            t0_valid_r, t0_valid_nxt;
  logic [SIZE_BITS-1:0]            t0_req_r, t0_req_nxt;
  logic                            res_granted_r, res_granted_nxt;
  logic [wfba_pkg::IDX_PORT_W-1:0] res_idx_r, res_idx_nxt;
  logic [wfba_pkg::SIZE_PORT_W-1:0] res_frag_r, res_frag_nxt;
  logic [wfba_pkg::SUM_W-1:0]      res_total_r, res_total_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_granted_r, out_granted_nxt;
  logic [wfba_pkg::IDX_PORT_W-1:0] out_idx_r, out_idx_nxt;
  logic [wfba_pkg::SIZE_PORT_W-1:0] out_frag_r, out_frag_nxt;
  logic [wfba_pkg::SUM_W-1:0]      out_total_r, out_total_nxt;

  wfba_pkg::cell_ctl_t             ctl;
  logic [AW-1:0]                   wr_addr;
  logic [SIZE_BITS-1:0]            req_size;
  logic [IDX_W-1:0]                mark_addr;
  logic                            in_accept;

  logic [MAX_BLOCKS:0]             tok_valid;
  logic [MAX_BLOCKS:0]             tok_found;
  logic [IDX_W-1:0]                tok_idx  [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0]            tok_best [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0]            tok_req  [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0]           cell_en;

  logic [SIZE_BITS-1:0]            frag;
  logic [ADD_W-1:0]                sum_ext;
  logic [wfba_pkg::SUM_W-1:0]      sum_new;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign wr_addr   = AW'(in_entry_index);
  assign req_size  = SIZE_BITS'(in_size_value);
  assign mark_addr = tok_idx[MAX_BLOCKS];

  // chain entry: fresh token, nothing found yet
  assign tok_valid[0] = t0_valid_r;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_best[0]  = '0;
  assign tok_req[0]   = t0_req_r;

  assign frag    = tok_best[MAX_BLOCKS] - tok_req[MAX_BLOCKS];
  assign sum_ext = ADD_W'(sum_r) + ADD_W'(frag);
  assign sum_new = (sum_ext > ADD_W'(wfba_pkg::SUM_MAX)) ? wfba_pkg::SUM_MAX
                                                         : wfba_pkg::SUM_W'(sum_ext);

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign cell_en[i] = (CW'(i) < CW'(blk_cnt_r));

    wfba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .AW        (AW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .wr_addr       (wr_addr),
      .wr_data       (req_size),
      .mark_addr     (mark_addr),
      .en            (cell_en[i]),
      .tok_valid_in  (tok_valid[i]),
      .tok_found_in  (tok_found[i]),
      .tok_idx_in    (tok_idx[i]),
      .tok_best_in   (tok_best[i]),
      .tok_req_in    (tok_req[i]),
      .tok_valid_out (tok_valid[i+1]),
      .tok_found_out (tok_found[i+1]),
      .tok_idx_out   (tok_idx[i+1]),
      .tok_best_out  (tok_best[i+1]),
      .tok_req_out   (tok_req[i+1])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    blk_cnt_nxt     = cfg_wr_en ? cfg_wr_data : blk_cnt_r;
    sum_nxt         = sum_r;
    last_nxt        = last_r;
    t0_valid_nxt    = 1'b0;
    t0_req_nxt      = t0_req_r;
    res_granted_nxt = res_granted_r;
    res_idx_nxt     = res_idx_r;
    res_frag_nxt    = res_frag_r;
    res_total_nxt   = res_total_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_idx_nxt     = out_idx_r;
    out_frag_nxt    = out_frag_r;
    out_total_nxt   = out_total_r;
    ctl             = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_command == wfba_pkg::CMD_LOAD) begin
            ctl.load        = 1'b1;
            res_granted_nxt = 1'b0;
            res_idx_nxt     = '0;
            res_frag_nxt    = '0;
            res_total_nxt   = sum_r;
            state_nxt       = ST_FINISH;
          end else begin
            t0_valid_nxt = 1'b1;
            t0_req_nxt   = req_size;
            last_nxt     = in_last_request;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok_valid[MAX_BLOCKS]) begin
          if (tok_found[MAX_BLOCKS]) begin
            ctl.mark        = 1'b1;
            res_granted_nxt = 1'b1;
            res_idx_nxt     = wfba_pkg::IDX_PORT_W'(tok_idx[MAX_BLOCKS]);
            res_frag_nxt    = wfba_pkg::SIZE_PORT_W'(frag);
            res_total_nxt   = sum_new;
            sum_nxt         = sum_new;
          end else begin
            res_granted_nxt = 1'b0;
            res_idx_nxt     = '0;
            res_frag_nxt    = '0;
            res_total_nxt   = sum_r;
          end
          // end of batch: drop all marks and the total after answering
          if (last_r) begin
            ctl.clear = 1'b1;
            sum_nxt   = '0;
          end
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_idx_nxt     = res_idx_r;
          out_frag_nxt    = res_frag_r;
          out_total_nxt   = res_total_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blk_cnt_r   <= '0;
      sum_r       <= '0;
      t0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      sum_r       <= sum_nxt;
      t0_valid_r  <= t0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r        <= last_nxt;
    t0_req_r      <= t0_req_nxt;
    res_granted_r <= res_granted_nxt;
    res_idx_r     <= res_idx_nxt;
    res_frag_r    <= res_frag_nxt;
    res_total_r   <= res_total_nxt;
    out_granted_r <= out_granted_nxt;
    out_idx_r     <= out_idx_nxt;
    out_frag_r    <= out_frag_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_granted_index  = out_idx_r;
  assign out_fragment       = out_frag_r;
  assign out_total_fragment = out_total_r;

  `WFBA_ASSERT_IMP(a_one_token, 1'b1, $countones(tok_valid) <= 1, "more than one search token")
  `WFBA_ASSERT_IMP(a_token_in_scan, tok_valid != '0, state_r == ST_SCAN, "token outside scan")
  `WFBA_ASSERT_NXT(a_req_launch, in_accept && (in_command == wfba_pkg::CMD_ALLOC), tok_valid[0], "request not launched")
  `WFBA_ASSERT_IMP(a_total_covers_frag, out_valid_r && out_granted_r, out_total_r >= wfba_pkg::SUM_W'(out_frag_r), "total below fragment")

endmodule

FILE: rtl/core/wfba_cell.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator cell
// Holds one block size and its used mark; compares the passing search token
// against its block and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module wfba_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int AW        = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wfba_pkg::cell_ctl_t  ctl,
  input  logic [AW-1:0]        wr_addr,
  input  logic [SIZE_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]     mark_addr,
  input  logic                 en,
  input  logic                 tok_valid_in,
  input  logic                 tok_found_in,
  input  logic [IDX_W-1:0]     tok_idx_in,
  input  logic [SIZE_BITS-1:0] tok_best_in,
  input  logic [SIZE_BITS-1:0] tok_req_in,
  output logic                 tok_valid_out,
  output logic                 tok_found_out,
  output logic [IDX_W-1:0]     tok_idx_out,
  output logic [SIZE_BITS-1:0] tok_best_out,
  output logic [SIZE_BITS-1:0] tok_req_out
);

  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 used_r, used_nxt;
  logic                 valid_r;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [SIZE_BITS-1:0] req_r;
  logic                 take;

  // strict compare keeps ties at the lower index
  assign take = en && !used_r && (size_r > tok_req_in) &&
                (!tok_found_in || (size_r > tok_best_in));

  always_comb begin
    size_nxt = size_r;
    if (ctl.load && (wr_addr == AW'(CELL_IDX))) begin
      size_nxt = wr_data;
    end
    used_nxt = used_r;
    if (ctl.clear) begin
      used_nxt = 1'b0;
    end else if (ctl.mark && (mark_addr == IDX_W'(CELL_IDX))) begin
      used_nxt = 1'b1;
    end
    found_nxt = tok_found_in | take;
    idx_nxt   = take ? IDX_W'(CELL_IDX) : tok_idx_in;
    best_nxt  = take ? size_r : tok_best_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      used_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      size_r  <= size_nxt;
      used_r  <= used_nxt;
      valid_r <= tok_valid_in;
    end
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    req_r   <= tok_req_in;
  end

  assign tok_valid_out = valid_r;
  assign tok_found_out = found_r;
  assign tok_idx_out   = idx_r;
  assign tok_best_out  = best_r;
  assign tok_req_out   = req_r;

endmodule

FILE: verif/worst_fit_block_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit block allocator testbench
// Loads block sizes and issues allocation requests, predicts every grant,
// fragment and running total, and compares each result item as it leaves,
// under random gaps on both channels across several block_count settings.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_top_tb;

  localparam int TABLE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 60;

  typedef struct {
    logic                             command;
    logic [wfba_pkg::IDX_PORT_W-1:0]  entry_index;
    logic [wfba_pkg::SIZE_PORT_W-1:0] size_value;
    logic                             last_request;
    bit                               hold_until_drained;
  } pending_item_t;

  typedef struct packed {
    logic                             granted;
    logic [wfba_pkg::IDX_PORT_W-1:0]  granted_index;
    logic [wfba_pkg::SIZE_PORT_W-1:0] fragment;
    logic [wfba_pkg::SUM_W-1:0]       total_fragment;
  } alloc_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [wfba_pkg::CNT_W-1:0]       cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_command = wfba_pkg::CMD_LOAD;
  logic [wfba_pkg::IDX_PORT_W-1:0]  in_entry_index = '0;
  logic [wfba_pkg::SIZE_PORT_W-1:0] in_size_value = '0;
  logic                             in_last_request = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_granted;
  logic [wfba_pkg::IDX_PORT_W-1:0]  out_granted_index;
  logic [wfba_pkg::SIZE_PORT_W-1:0] out_fragment;
  logic [wfba_pkg::SUM_W-1:0]       out_total_fragment;

  // predictor state
  logic [wfba_pkg::SIZE_PORT_W-1:0] block_size_tbl [TABLE_DEPTH];
  bit   [TABLE_DEPTH-1:0]           block_used;
  logic [wfba_pkg::SUM_W-1:0]       fragment_total;
  logic [wfba_pkg::CNT_W-1:0]       active_count;

  pending_item_t pending_items[$];
  alloc_result_t expected_grants[$];
  pending_item_t cur_item;
  alloc_result_t got_result;
  alloc_result_t want_result;

  bit offering;
  int sender_gap;
  int receiver_wait;
  int hold_left;
  int hold_requests;
  int hold_served;
  bit sender_gaps_on;
  bit receiver_gaps_on;
  int mismatches;
  int cycle_count;

  worst_fit_block_allocator_top #(
    .MAX_BLOCKS(TABLE_DEPTH),
    .SIZE_BITS (16)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_size_value     (in_size_value),
    .in_last_request   (in_last_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted       (out_granted),
    .out_granted_index (out_granted_index),
    .out_fragment      (out_fragment),
    .out_total_fragment(out_total_fragment)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one item to the predicted allocator state and return its result.
  function automatic alloc_result_t serve_item(input pending_item_t it);
    alloc_result_t                    r;
    int                               lim;
    int                               i;
    bit                               found;
    logic [wfba_pkg::IDX_PORT_W-1:0]  best;
    logic [wfba_pkg::SIZE_PORT_W-1:0] best_size;
    logic [wfba_pkg::SUM_W:0]         sum_wide;
    r = '0;
    if (it.command == wfba_pkg::CMD_LOAD) begin
      block_size_tbl[it.entry_index] = it.size_value;
    end else begin
      lim = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
      found = 1'b0;
      best = '0;
      best_size = '0;
      // strictly larger only, so ties keep the lowest index
      for (i = 0; i < lim; i++) begin
        if (!block_used[i] && block_size_tbl[i] > it.size_value &&
            (!found || block_size_tbl[i] > best_size)) begin
          found = 1'b1;
          best = i[wfba_pkg::IDX_PORT_W-1:0];
          best_size = block_size_tbl[i];
        end
      end
      if (found) begin
        block_used[best] = 1'b1;
        r.granted = 1'b1;
        r.granted_index = best;
        r.fragment = best_size - it.size_value;
        sum_wide = {1'b0, fragment_total} + r.fragment;
        fragment_total = (sum_wide > wfba_pkg::SUM_MAX) ? wfba_pkg::SUM_MAX
                                                        : sum_wide[wfba_pkg::SUM_W-1:0];
      end
    end
    r.total_fragment = fragment_total;
    if (it.command == wfba_pkg::CMD_ALLOC && it.last_request) begin
      block_used = '0;
      fragment_total = '0;
    end
    return r;
  endfunction

  function automatic void queue_item(input logic cmd, input int idx, input int size,
                                     input logic last);
    pending_item_t it;
    it.command = cmd;
    it.entry_index = idx[wfba_pkg::IDX_PORT_W-1:0];
    it.size_value = size[wfba_pkg::SIZE_PORT_W-1:0];
    it.last_request = last;
    it.hold_until_drained = 1'b0;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_drain_pause();
    pending_item_t it;
    it = '{default: '0};
    it.hold_until_drained = 1'b1;
    pending_items.push_back(it);
  endfunction

  // Mix of full range, near the top, tiny and mid sizes.
  function automatic int pick_size(input int top_mode);
    case ($urandom_range(0, top_mode))
      0: pick_size = $urandom_range(0, 65535);
      1: pick_size = $urandom_range(0, 255);
      2: pick_size = $urandom_range(1000, 30000);
      default: pick_size = $urandom_range(60000, 65535);
    endcase
  endfunction

  // One batch: some loads, then requests, usually closed by a last request.
  function automatic int queue_batch();
    int n_loads;
    int n_reqs;
    int k;
    bit broken;
    n_loads = $urandom_range(0, 5);
    n_reqs = $urandom_range(1, 18);
    broken = ($urandom_range(0, 7) == 0);
    for (k = 0; k < n_loads; k++)
      queue_item(wfba_pkg::CMD_LOAD, $urandom_range(0, 15), pick_size(3),
                 $urandom_range(0, 7) == 0);
    for (k = 0; k < n_reqs; k++) begin
      if (k == n_reqs - 1 && !broken)
        queue_item(wfba_pkg::CMD_ALLOC, $urandom_range(0, 15), pick_size(2), 1'b1);
      else
        queue_item(wfba_pkg::CMD_ALLOC, $urandom_range(0, 15), pick_size(2),
                   $urandom_range(0, 15) == 0);
    end
    return n_loads + n_reqs;
  endfunction

  // Driver: present pending items, hold them while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      offering = 1'b0;
      sender_gap = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_grants.push_back(serve_item(cur_item));
        offering = 1'b0;
        sender_gap = sender_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (!offering) begin
        if (sender_gap != 0) begin
          sender_gap--;
        end else if (pending_items.size() != 0 && pending_items[0].hold_until_drained) begin
          if (expected_grants.size() == 0)
            void'(pending_items.pop_front());
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_command <= cur_item.command;
          in_entry_index <= cur_item.entry_index;
          in_size_value <= cur_item.size_value;
          in_last_request <= cur_item.last_request;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: got g=%0b idx=%0d frag=%0d total=%0d",
               $realtime, what, got_result.granted, got_result.granted_index,
               got_result.fragment, got_result.total_fragment);
      $display("    want g=%0b idx=%0d frag=%0d total=%0d",
               want_result.granted, want_result.granted_index,
               want_result.fragment, want_result.total_fragment);
    end
  endtask

  // Monitor and receiver stall control.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_result = {out_granted, out_granted_index, out_fragment, out_total_fragment};
        if (expected_grants.size() == 0) begin
          want_result = '0;
          note_mismatch("result with nothing expected");
        end else begin
          want_result = expected_grants.pop_front();
          if (got_result !== want_result)
            note_mismatch("result mismatch");
        end
        receiver_wait = receiver_gaps_on ? $urandom_range(0, 19) : 0;
      end else if (receiver_wait != 0) begin
        receiver_wait--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0) || (receiver_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || offering || expected_grants.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[wfba_pkg::CNT_W-1:0];
    active_count = value[wfba_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  int phase_counts[8] = '{16, 31, 0, 16, 1, 17, 0, 16};
  int phase;
  int added;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++)
      block_size_tbl[i] = '0;
    block_used = '0;
    fragment_total = '0;
    active_count = '0;
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;
    phase_counts[6] = $urandom_range(2, 15);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of zero: nothing can be granted
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);
    wait_idle();
    write_block_count(TABLE_DEPTH);

    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);          // all blocks empty
    queue_item(wfba_pkg::CMD_LOAD, 0, 16'hFFFF, 1'b0);
    queue_item(wfba_pkg::CMD_LOAD, 15, 16'hFFFF, 1'b1);   // last flag on a load is ignored
    queue_item(wfba_pkg::CMD_LOAD, 5, 16'h8000, 1'b0);
    queue_item(wfba_pkg::CMD_LOAD, 6, 16'h0001, 1'b0);
    queue_item(wfba_pkg::CMD_LOAD, 10, 16'h7FFF, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);          // tie, lowest index wins
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 16'hFFFF, 1'b0);   // nothing larger
    queue_item(wfba_pkg::CMD_ALLOC, 0, 16'h8000, 1'b0);   // equal size does not fit
    queue_item(wfba_pkg::CMD_ALLOC, 15, 16'h7FFF, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);
    queue_item(wfba_pkg::CMD_LOAD, 0, 5, 1'b0);           // reload keeps the used mark
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b1);          // no fit, end of batch
    queue_item(wfba_pkg::CMD_ALLOC, 0, 0, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 16'hFFFE, 1'b1);
    queue_item(wfba_pkg::CMD_LOAD, 15, 0, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 3, 1'b0);
    queue_item(wfba_pkg::CMD_ALLOC, 0, 16'hFFFF, 1'b1);
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      write_block_count(phase_counts[phase]);
      sender_gaps_on = (phase % 3) != 1;
      receiver_gaps_on = (phase % 4) != 2;
      if (phase == 3) begin
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
      end
      added = 0;
      while (added < PHASE_ITEMS / 2)
        added += queue_batch();
      // sender waits here until every result so far is back
      if (phase == 2)
        queue_drain_pause();
      while (added < PHASE_ITEMS)
        added += queue_batch();
      // receiver holds off while the sender keeps offering
      if (phase == 1 || phase == 5)
        hold_requests++;
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_grants.size() != 0)
      $display("%0d result items never arrived", expected_grants.size());
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wfba_pkg.sv
rtl/core/wfba_cell.sv
rtl/core/worst_fit_block_allocator_top.sv
verif/worst_fit_block_allocator_top_tb.sv
